[rtl/sbf_pkg.sv]
// Shared constants, opcodes and controller/datapath handshake structs for
// the sprite blitter. No dependencies.
package sbf_pkg;

  // screen and sprite geometry
  localparam int SCREEN_WIDTH_BYTES = 80;
  localparam int SCREEN_HEIGHT_ROWS = 480;
  localparam int SPRITE_SLOT_BYTES  = 128;
  localparam int SPRITE_KINDS       = 3;
  localparam int MAX_SPRITE_W       = 4;
  localparam int MAX_SPRITE_H       = 32;

  localparam int FRAME_BYTES = SCREEN_WIDTH_BYTES * SCREEN_HEIGHT_ROWS;
  localparam int PAT_BYTES   = SPRITE_KINDS * SPRITE_SLOT_BYTES;
  localparam int FB_AW       = $clog2(FRAME_BYTES);
  localparam int PAT_AW      = $clog2(PAT_BYTES);
  localparam int CW_W        = $clog2(MAX_SPRITE_W);
  localparam int RW_W        = $clog2(MAX_SPRITE_H);
  localparam int PI_W        = $clog2(MAX_SPRITE_W * MAX_SPRITE_H);

  // field widths
  localparam int OP_W       = 3;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 9;
  localparam int KIND_W     = 2;
  localparam int PIDX_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int WREG_W     = 3;
  localparam int HREG_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW  = 3'd0,
    OP_ERASE = 3'd1,
    OP_CLEAR = 3'd2,
    OP_READ  = 3'd3,
    OP_LOAD  = 3'd4
  } sbf_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAYER_W = 3'd0,
    CFG_PLAYER_H = 3'd1,
    CFG_SHOT_W   = 3'd2,
    CFG_SHOT_H   = 3'd3,
    CFG_ALIEN_W  = 3'd4,
    CFG_ALIEN_H  = 3'd5
  } sbf_cfg_idx_t;

  localparam logic [KIND_W-1:0] KIND_PLAYER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHOT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALIEN  = 2'd2;

  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;

  typedef enum logic [2:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_READ,
    ST_BLIT_RD,
    ST_BLIT_WR,
    ST_DONE
  } sbf_state_t;

  typedef struct packed {
    logic sweep_init;   // restart sweep address at zero
    logic sweep_step;   // zero one frame byte, advance
    logic sweep_pat;    // also zero the pattern store during the sweep
    logic blit_init;    // load blit counters from the item
    logic blit_rd;      // read frame and pattern bytes
    logic blit_wr;      // write merged byte, advance counters
    logic item_rd;      // read the frame byte the item addresses
    logic pat_load;     // store a pattern byte
    logic res_clear;
    logic res_read;
    logic res_placed;
    logic out_load;
  } sbf_cmd_t;

  typedef struct packed {
    sbf_op_t op;
    logic    blit_ok;
    logic    blit_last;
    logic    sweep_last;
    logic    out_free;
  } sbf_sts_t;

endpackage

[rtl/sbf_if.sv]
// Valid/ready channel interfaces for the blitter's item and result words.
// Depends on sbf_pkg for field widths.
interface sbf_in_if;
  logic                           valid;
  logic                           ready;
  logic [sbf_pkg::OP_W-1:0]       opcode;
  logic [sbf_pkg::COL_W-1:0]      column;
  logic [sbf_pkg::ROW_W-1:0]      row;
  logic [sbf_pkg::KIND_W-1:0]     sprite_kind;
  logic [sbf_pkg::PIDX_W-1:0]     pattern_index;
  logic [sbf_pkg::BYTE_W-1:0]     pattern_value;

  modport source (output valid, opcode, column, row, sprite_kind, pattern_index,
                  pattern_value, input ready);
  modport sink   (input valid, opcode, column, row, sprite_kind, pattern_index,
                  pattern_value, output ready);
endinterface

interface sbf_out_if;
  logic                       valid;
  logic                       ready;
  logic [sbf_pkg::BYTE_W-1:0] read_value;
  logic                       placed;

  modport source (output valid, read_value, placed, input ready);
  modport sink   (input valid, read_value, placed, output ready);
endinterface

[rtl/sbf_ctrl.sv]
// Sequencer for the blitter: decodes the held word and steps the datapath
// through sweeps, reads and read-modify-write loops. Depends on sbf_pkg.
module sbf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  sbf_pkg::sbf_sts_t sts,
  output sbf_pkg::sbf_cmd_t cmd,
  output logic              in_ready
);
  import sbf_pkg::*;

  sbf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT_CLR: if (sts.sweep_last) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_fire) state_nxt = ST_DECODE;
      ST_DECODE: begin
        unique case (sts.op)
          OP_DRAW, OP_ERASE: state_nxt = sts.blit_ok ? ST_BLIT_RD : ST_DONE;
          OP_CLEAR:          state_nxt = ST_CLEAR;
          OP_READ:           state_nxt = ST_READ;
          default:           state_nxt = ST_DONE;
        endcase
      end
      ST_CLEAR:    if (sts.sweep_last) state_nxt = ST_DONE;
      ST_READ:     state_nxt = ST_DONE;
      ST_BLIT_RD:  state_nxt = ST_BLIT_WR;
      ST_BLIT_WR:  state_nxt = sts.blit_last ? ST_DONE : ST_BLIT_RD;
      ST_DONE:     if (sts.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_INIT_CLR: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_pat  = 1'b1;
      end
      ST_IDLE: in_ready = 1'b1;
      ST_DECODE: begin
        cmd.res_clear = 1'b1;
        unique case (sts.op)
          OP_DRAW, OP_ERASE: cmd.blit_init = sts.blit_ok;
          OP_CLEAR:          cmd.sweep_init = 1'b1;
          OP_READ:           cmd.item_rd = 1'b1;
          OP_LOAD:           cmd.pat_load = 1'b1;
          default:           ;
        endcase
      end
      ST_CLEAR:   cmd.sweep_step = 1'b1;
      ST_READ:    cmd.res_read = 1'b1;
      ST_BLIT_RD: cmd.blit_rd = 1'b1;
      ST_BLIT_WR: begin
        cmd.blit_wr    = 1'b1;
        cmd.res_placed = sts.blit_last;
      end
      ST_DONE:    cmd.out_load = sts.out_free;
      default:    ;
    endcase
  end

  // result only moves into a free output register
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending word");

  // every merge write uses data fetched the cycle before
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.blit_wr |-> $past(cmd.blit_rd))
    else $error("blit write without preceding read");

  // no word taken while the power-up sweep runs
  a_no_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INIT_CLR |-> !in_fire)
    else $error("word accepted during power-up clear");

  // a placed result only at the end of a blit loop
  a_placed_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_placed |-> cmd.blit_wr && sts.blit_last)
    else $error("placed flag outside blit end");

endmodule

[rtl/sbf_dp.sv]
// Datapath of the blitter: frame and pattern memories, size registers,
// blit counters and the output register. Depends on sbf_pkg.
module sbf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic [sbf_pkg::OP_W-1:0]      in_opcode,
  input  logic [sbf_pkg::COL_W-1:0]     in_column,
  input  logic [sbf_pkg::ROW_W-1:0]     in_row,
  input  logic [sbf_pkg::KIND_W-1:0]    in_sprite_kind,
  input  logic [sbf_pkg::PIDX_W-1:0]    in_pattern_index,
  input  logic [sbf_pkg::BYTE_W-1:0]    in_pattern_value,
  input  logic                          cfg_we,
  input  logic [sbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  sbf_pkg::sbf_cmd_t             cmd,
  output sbf_pkg::sbf_sts_t             sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [sbf_pkg::BYTE_W-1:0]    out_read_value,
  output logic                          out_placed
);
  import sbf_pkg::*;

  // size registers
  logic [WREG_W-1:0] player_w_r, shot_w_r, alien_w_r;
  logic [HREG_W-1:0] player_h_r, shot_h_r, alien_h_r;

  // held item word
  sbf_op_t            op_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [KIND_W-1:0]  kind_r;
  logic [PIDX_W-1:0]  pidx_r;
  logic [BYTE_W-1:0]  pval_r;

  // sweep / blit state
  logic [FB_AW-1:0]   fa_r;
  logic [CW_W-1:0]    c_r;
  logic [RW_W-1:0]    r_r;
  logic [PI_W-1:0]    pr_r;

  // memories
  logic [BYTE_W-1:0]  fb_mem [FRAME_BYTES];
  logic [BYTE_W-1:0]  pat_mem [PAT_BYTES];
  logic [BYTE_W-1:0]  fb_q_r, pat_q_r;
  logic               pi_ok_r;

  // pending and output result
  logic [BYTE_W-1:0]  res_val_r;
  logic               res_placed_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_val_r;
  logic               out_placed_r;

  logic [WREG_W-1:0]  w_raw, w;
  logic [HREG_W-1:0]  h_raw, h;
  logic [FB_AW-1:0]   item_addr;
  logic               item_in_screen;
  logic               load_ok;
  logic [PI_W-1:0]    pi;
  logic               pi_ok;
  logic [PAT_AW-1:0]  pat_raddr, pat_waddr;
  logic               pat_we;
  logic [BYTE_W-1:0]  pat_wdata;
  logic [FB_AW-1:0]   fb_raddr;
  logic               fb_re, fb_we;
  logic [BYTE_W-1:0]  fb_wdata, p_byte;
  logic               sweep_pat_hit;
  logic               col_fits, row_fits;
  logic               row_end;

  // clamped size of the held sprite kind
  always_comb begin
    priority case (kind_r)
      KIND_PLAYER: begin w_raw = player_w_r; h_raw = player_h_r; end
      KIND_SHOT:   begin w_raw = shot_w_r;   h_raw = shot_h_r;   end
      default:     begin w_raw = alien_w_r;  h_raw = alien_h_r;  end
    endcase
    if (w_raw == '0) w = WREG_W'(1);
    else if (w_raw > WREG_W'(MAX_SPRITE_W)) w = WREG_W'(MAX_SPRITE_W);
    else w = w_raw;
    if (h_raw == '0) h = HREG_W'(1);
    else if (h_raw > HREG_W'(MAX_SPRITE_H)) h = HREG_W'(MAX_SPRITE_H);
    else h = h_raw;
  end

  assign item_addr = FB_AW'(row_r) * FB_AW'(SCREEN_WIDTH_BYTES) + FB_AW'(col_r);
  assign item_in_screen = (32'(col_r) < SCREEN_WIDTH_BYTES) &&
                          (32'(row_r) < SCREEN_HEIGHT_ROWS);
  assign col_fits = (32'(col_r) + 32'(w)) < SCREEN_WIDTH_BYTES;
  assign row_fits = (32'(row_r) + 32'(h)) < SCREEN_HEIGHT_ROWS;
  assign load_ok  = (32'(kind_r) < SPRITE_KINDS) && (32'(pidx_r) < SPRITE_SLOT_BYTES);

  // pattern rows run in reversed byte order
  assign pi    = pr_r + PI_W'(w) - PI_W'(1) - PI_W'(c_r);
  assign pi_ok = 32'(pi) < SPRITE_SLOT_BYTES;
  assign row_end = (c_r == CW_W'(w - WREG_W'(1)));

  assign sts.op         = op_r;
  assign sts.blit_ok    = (32'(kind_r) < SPRITE_KINDS) && (col_r != '0) &&
                          (row_r != '0) && col_fits && row_fits;
  assign sts.blit_last  = row_end && (r_r == RW_W'(h - HREG_W'(1)));
  assign sts.sweep_last = (fa_r == FB_AW'(FRAME_BYTES - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  // frame memory ports
  assign p_byte   = pi_ok_r ? pat_q_r : BYTE_ZERO;
  assign fb_re    = cmd.item_rd || cmd.blit_rd;
  assign fb_raddr = cmd.item_rd ? item_addr : fa_r;
  assign fb_we    = cmd.sweep_step || cmd.blit_wr;
  assign fb_wdata = cmd.sweep_step ? BYTE_ZERO :
                    (op_r == OP_ERASE) ? (fb_q_r & ~p_byte) : (fb_q_r | p_byte);

  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fa_r] <= fb_wdata;
    if (fb_re) fb_q_r <= fb_mem[fb_raddr];
  end

  // pattern memory ports
  assign sweep_pat_hit = cmd.sweep_step && cmd.sweep_pat && (32'(fa_r) < PAT_BYTES);
  assign pat_we    = (cmd.pat_load && load_ok) || sweep_pat_hit;
  assign pat_waddr = sweep_pat_hit ? fa_r[PAT_AW-1:0] :
                     PAT_AW'(kind_r) * PAT_AW'(SPRITE_SLOT_BYTES) + PAT_AW'(pidx_r);
  assign pat_wdata = sweep_pat_hit ? BYTE_ZERO : pval_r;
  assign pat_raddr = PAT_AW'(kind_r) * PAT_AW'(SPRITE_SLOT_BYTES) + PAT_AW'(pi);

  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pat_waddr] <= pat_wdata;
    if (cmd.blit_rd) begin
      pat_q_r <= pat_mem[pat_raddr];
      pi_ok_r <= pi_ok;
    end
  end

  // item capture, counters, pending result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= sbf_op_t'(in_opcode);
      col_r  <= in_column;
      row_r  <= in_row;
      kind_r <= in_sprite_kind;
      pidx_r <= in_pattern_index;
      pval_r <= in_pattern_value;
    end
    if (cmd.blit_init) begin
      c_r  <= '0;
      r_r  <= '0;
      pr_r <= '0;
    end else if (cmd.blit_wr) begin
      if (row_end) begin
        c_r  <= '0;
        r_r  <= r_r + RW_W'(1);
        pr_r <= pr_r + PI_W'(w);
      end else begin
        c_r <= c_r + CW_W'(1);
      end
    end
    if (cmd.res_clear) begin
      res_val_r    <= BYTE_ZERO;
      res_placed_r <= 1'b0;
    end else begin
      if (cmd.res_read) res_val_r <= item_in_screen ? fb_q_r : BYTE_ZERO;
      if (cmd.res_placed) res_placed_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_val_r    <= res_val_r;
      out_placed_r <= res_placed_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_r        <= '0;
      out_valid_r <= 1'b0;
      player_w_r  <= WREG_W'(4);
      player_h_r  <= HREG_W'(32);
      shot_w_r    <= WREG_W'(2);
      shot_h_r    <= HREG_W'(16);
      alien_w_r   <= WREG_W'(4);
      alien_h_r   <= HREG_W'(32);
    end else begin
      if (cmd.sweep_init) begin
        fa_r <= '0;
      end else if (cmd.blit_init) begin
        fa_r <= item_addr;
      end else if (cmd.sweep_step) begin
        fa_r <= sts.sweep_last ? '0 : fa_r + FB_AW'(1);
      end else if (cmd.blit_wr) begin
        // end of row jumps to the sprite's first byte in the next screen row
        fa_r <= row_end ? fa_r + FB_AW'(SCREEN_WIDTH_BYTES + 1) - FB_AW'(w)
                        : fa_r + FB_AW'(1);
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PLAYER_W: player_w_r <= cfg_wdata[WREG_W-1:0];
          CFG_PLAYER_H: player_h_r <= cfg_wdata[HREG_W-1:0];
          CFG_SHOT_W:   shot_w_r   <= cfg_wdata[WREG_W-1:0];
          CFG_SHOT_H:   shot_h_r   <= cfg_wdata[HREG_W-1:0];
          CFG_ALIEN_W:  alien_w_r  <= cfg_wdata[WREG_W-1:0];
          CFG_ALIEN_H:  alien_h_r  <= cfg_wdata[HREG_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_val_r;
  assign out_placed     = out_placed_r;

endmodule

[rtl/sprite_blit_frame_buffer.sv]
// Top level of the monochrome sprite blitter: controller plus datapath.
// Depends on sbf_pkg, sbf_if, sbf_ctrl and sbf_dp.
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    opcode, column, row, sprite_kind,
//                                pattern_index, pattern_value
//   out_ch   out  valid/ready    read_value, placed
//   cfg_*    in   cfg_we only    cfg_index, cfg_wdata
//
// One word at a time. Draw/erase: each sprite byte is read, then merged
// and written back to the frame memory. Clear: one frame byte per cycle.
// After reset a sweep over all 38400 frame bytes zeroes the frame and pattern
// memories; in_ch stays not ready until it ends. A stalled out_ch holds the
// finished word in the output register; the next word is accepted meanwhile.
module sprite_blit_frame_buffer (
  input  logic                           clk,
  input  logic                           rst_n,
  sbf_in_if.sink                         in_ch,
  sbf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [sbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sbf_pkg::*;

  sbf_cmd_t cmd;
  sbf_sts_t sts;
  logic     in_ready;
  logic     in_fire;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  sbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  sbf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .in_opcode        (in_ch.opcode),
    .in_column        (in_ch.column),
    .in_row           (in_ch.row),
    .in_sprite_kind   (in_ch.sprite_kind),
    .in_pattern_index (in_ch.pattern_index),
    .in_pattern_value (in_ch.pattern_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_read_value   (out_ch.read_value),
    .out_placed       (out_ch.placed)
  );

endmodule

[tb/sv/sbf_blit_checker.sv]
// Result checker for the sprite blitter: watches the item, result and register ports,
// keeps its own frame and pattern stores, and compares every result word.
// Depends on sbf_pkg and the sbf_in_if / sbf_out_if interfaces.
module sbf_blit_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  sbf_in_if                              in_ch,
  sbf_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [sbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    mismatch_count,
  output int unsigned                    results_owed
);
  import sbf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] read_value;
    logic              placed;
  } blit_result_t;

  logic [BYTE_W-1:0] frame_mem   [FRAME_BYTES];
  logic [BYTE_W-1:0] pattern_mem [PAT_BYTES];
  logic [WREG_W-1:0] width_reg   [SPRITE_KINDS];
  logic [HREG_W-1:0] height_reg  [SPRITE_KINDS];
  blit_result_t      due_q [$];

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // OR or AND-NOT one sprite into the frame; 1 when carried out
  function automatic logic blit(logic [KIND_W-1:0] kind, int x, int y, logic erase);
    int w, h, r, c, pi, addr;
    logic [BYTE_W-1:0] p;
    if (kind > KIND_ALIEN) return 1'b0;
    w = clamp(int'(width_reg[kind]), 1, MAX_SPRITE_W);
    h = clamp(int'(height_reg[kind]), 1, MAX_SPRITE_H);
    if (x == 0 || y == 0) return 1'b0;
    if (x + w >= SCREEN_WIDTH_BYTES) return 1'b0;
    if (y + h >= SCREEN_HEIGHT_ROWS) return 1'b0;
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        // pattern bytes run right to left within a row
        pi = r * w + (w - 1 - c);
        p = (pi < SPRITE_SLOT_BYTES) ? pattern_mem[int'(kind) * SPRITE_SLOT_BYTES + pi]
                                     : BYTE_ZERO;
        addr = (y + r) * SCREEN_WIDTH_BYTES + x + c;
        if (addr < FRAME_BYTES) begin
          if (erase) frame_mem[addr] = frame_mem[addr] & ~p;
          else frame_mem[addr] = frame_mem[addr] | p;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic blit_result_t frame_step(logic [OP_W-1:0] op, int col, int row,
                                              logic [KIND_W-1:0] kind, int pidx,
                                              logic [BYTE_W-1:0] pval);
    blit_result_t res;
    res = '0;
    case (op)
      OP_DRAW:  res.placed = blit(kind, col, row, 1'b0);
      OP_ERASE: res.placed = blit(kind, col, row, 1'b1);
      OP_CLEAR: begin
        for (int i = 0; i < FRAME_BYTES; i++) frame_mem[i] = BYTE_ZERO;
      end
      OP_READ: begin
        if (col < SCREEN_WIDTH_BYTES && row < SCREEN_HEIGHT_ROWS)
          res.read_value = frame_mem[row * SCREEN_WIDTH_BYTES + col];
      end
      OP_LOAD: begin
        if (kind <= KIND_ALIEN && pidx < SPRITE_SLOT_BYTES)
          pattern_mem[int'(kind) * SPRITE_SLOT_BYTES + pidx] = pval;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    blit_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < FRAME_BYTES; i++) frame_mem[i] = BYTE_ZERO;
      for (int i = 0; i < PAT_BYTES; i++) pattern_mem[i] = BYTE_ZERO;
      width_reg[KIND_PLAYER]  = 3'd4;
      height_reg[KIND_PLAYER] = 6'd32;
      width_reg[KIND_SHOT]    = 3'd2;
      height_reg[KIND_SHOT]   = 6'd16;
      width_reg[KIND_ALIEN]   = 3'd4;
      height_reg[KIND_ALIEN]  = 6'd32;
      due_q.delete();
    end else begin
      // a result word leaving now belongs to an earlier item
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result word: read_value %0h placed %0b",
                 out_ch.read_value, out_ch.placed);
          mismatch_count++;
        end else begin
          want = due_q.pop_front();
          if (out_ch.read_value !== want.read_value) begin
            $error("read_value: expected %0h, got %0h", want.read_value, out_ch.read_value);
            mismatch_count++;
          end
          if (out_ch.placed !== want.placed) begin
            $error("placed: expected %0b, got %0b", want.placed, out_ch.placed);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        due_q.push_back(frame_step(in_ch.opcode, int'(in_ch.column), int'(in_ch.row),
                                   in_ch.sprite_kind, int'(in_ch.pattern_index),
                                   in_ch.pattern_value));
      if (cfg_we) begin
        case (cfg_index)
          CFG_PLAYER_W: width_reg[KIND_PLAYER]  = cfg_wdata[WREG_W-1:0];
          CFG_PLAYER_H: height_reg[KIND_PLAYER] = cfg_wdata[HREG_W-1:0];
          CFG_SHOT_W:   width_reg[KIND_SHOT]    = cfg_wdata[WREG_W-1:0];
          CFG_SHOT_H:   height_reg[KIND_SHOT]   = cfg_wdata[HREG_W-1:0];
          CFG_ALIEN_W:  width_reg[KIND_ALIEN]   = cfg_wdata[WREG_W-1:0];
          CFG_ALIEN_H:  height_reg[KIND_ALIEN]  = cfg_wdata[HREG_W-1:0];
          default: ;
        endcase
      end
    end
    results_owed = due_q.size();
  end

endmodule

[tb/sv/tb_sprite_blit_frame_buffer.sv]
// Top of the sprite blitter testbench: clock, reset, item and register stimulus,
// random result back-pressure, verdict. Depends on sbf_pkg, the channel interfaces,
// sprite_blit_frame_buffer and sbf_blit_checker.
module tb_sprite_blit_frame_buffer;
  import sbf_pkg::*;

  localparam logic [OP_W-1:0]      OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0]      OP_SPARE_HI  = 3'd7;
  localparam logic [KIND_W-1:0]    KIND_NONE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           mismatch_count;
  int unsigned           results_owed;
  bit                    calm;
  int                    last_col;
  int                    last_row;
  int                    clears_left;

  sbf_in_if  in_ch ();
  sbf_out_if out_ch ();

  sprite_blit_frame_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sbf_blit_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #25_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall before taking each word
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // called and returns at a falling edge
  task automatic send_word(input logic [OP_W-1:0] op, input int col, input int row,
                           input logic [KIND_W-1:0] kind, input int pidx, input int pval);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.column        <= col[COL_W-1:0];
    in_ch.row           <= row[ROW_W-1:0];
    in_ch.sprite_kind   <= kind;
    in_ch.pattern_index <= pidx[PIDX_W-1:0];
    in_ch.pattern_value <= pval[BYTE_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  task automatic write_sizes(input int pw, input int ph, input int sw, input int sh,
                             input int aw, input int ah);
    put_reg(CFG_PLAYER_W, pw);
    put_reg(CFG_PLAYER_H, ph);
    put_reg(CFG_SHOT_W, sw);
    put_reg(CFG_SHOT_H, sh);
    put_reg(CFG_ALIEN_W, aw);
    put_reg(CFG_ALIEN_H, ah);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // drop valid so the last word is not taken again, then drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_word();
    int pick, sel, col, row;
    logic [KIND_W-1:0] kind;
    pick = $urandom_range(0, 99);
    kind = ($urandom_range(0, 15) == 0) ? KIND_NONE
                                        : KIND_W'($urandom_range(KIND_PLAYER, KIND_ALIEN));
    if (pick < 25) begin
      send_word(OP_LOAD, $urandom_range(0, 127), $urandom_range(0, 511), kind,
                $urandom_range(0, 127), $urandom_range(0, 255));
    end else if (pick < 62) begin
      // mostly legal corners, some near the right and bottom edges, some anywhere
      sel = $urandom_range(0, 9);
      col = (sel == 0) ? $urandom_range(0, 127) :
            (sel == 1) ? $urandom_range(74, 80) : $urandom_range(1, 75);
      sel = $urandom_range(0, 9);
      row = (sel == 0) ? $urandom_range(0, 511) :
            (sel == 1) ? $urandom_range(444, 480) : $urandom_range(1, 447);
      last_col = col;
      last_row = row;
      send_word((pick < 50) ? OP_DRAW : OP_ERASE, col, row, kind,
                $urandom_range(0, 127), $urandom_range(0, 255));
    end else if (pick < 95) begin
      // reads mostly land on the last sprite
      if ($urandom_range(0, 9) < 7) begin
        col = last_col + $urandom_range(0, 3);
        row = last_row + $urandom_range(0, 31);
      end else begin
        col = $urandom_range(0, 127);
        row = $urandom_range(0, 511);
      end
      send_word(OP_READ, col, row, kind, $urandom_range(0, 127), $urandom_range(0, 255));
    end else if (pick < 97 && clears_left > 0) begin
      clears_left--;
      send_word(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 511), kind,
                $urandom_range(0, 127), $urandom_range(0, 255));
    end else begin
      send_word(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom_range(0, 127),
                $urandom_range(0, 511), kind, $urandom_range(0, 127), $urandom_range(0, 255));
    end
  endtask

  task automatic random_words(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      random_word();
    end
    calm = 1'b0;
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_READ;
    in_ch.column        = '0;
    in_ch.row           = '0;
    in_ch.sprite_kind   = KIND_PLAYER;
    in_ch.pattern_index = '0;
    in_ch.pattern_value = '0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_PLAYER_W;
    cfg_wdata           = '0;
    rst_n               = 1'b0;
    calm                = 1'b0;
    last_col            = 1;
    last_row            = 1;
    clears_left         = 6;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset sizes: player 4x32, shot 2x16, alien 4x32
    send_word(OP_READ, 0, 0, KIND_PLAYER, 0, 0);
    send_word(OP_LOAD, 0, 0, KIND_PLAYER, 0, 'hFF);
    send_word(OP_LOAD, 0, 0, KIND_PLAYER, 3, 'h81);
    send_word(OP_LOAD, 0, 0, KIND_PLAYER, 127, 'hA5);
    send_word(OP_LOAD, 0, 0, KIND_NONE, 5, 'hFF);
    send_word(OP_LOAD, 0, 0, KIND_SHOT, 0, 'h3C);
    send_word(OP_LOAD, 0, 0, KIND_ALIEN, 0, 'h00);
    send_word(OP_DRAW, 1, 1, KIND_PLAYER, 0, 0);
    send_word(OP_READ, 1, 1, KIND_PLAYER, 0, 0);     // reversed row order
    send_word(OP_READ, 4, 1, KIND_PLAYER, 0, 0);
    send_word(OP_DRAW, 0, 5, KIND_PLAYER, 0, 0);     // zero column
    send_word(OP_DRAW, 5, 0, KIND_PLAYER, 0, 0);     // zero row
    send_word(OP_DRAW, 76, 5, KIND_PLAYER, 0, 0);    // touches right edge
    send_word(OP_DRAW, 5, 448, KIND_PLAYER, 0, 0);   // touches bottom edge
    send_word(OP_DRAW, 5, 5, KIND_NONE, 0, 0);
    send_word(OP_DRAW, 75, 447, KIND_PLAYER, 0, 0);  // furthest legal corner
    send_word(OP_READ, 75, 478, KIND_PLAYER, 0, 0);
    send_word(OP_ERASE, 1, 1, KIND_PLAYER, 0, 0);
    send_word(OP_READ, 1, 1, KIND_PLAYER, 0, 0);
    send_word(OP_DRAW, 10, 10, KIND_SHOT, 0, 0);
    send_word(OP_READ, 11, 10, KIND_SHOT, 0, 0);
    send_word(OP_ERASE, 20, 20, KIND_ALIEN, 0, 0);   // placed with no bit changing
    send_word(OP_READ, 127, 511, KIND_NONE, 127, 'hFF);
    send_word(OP_SPARE_LO, 3, 3, KIND_PLAYER, 0, 0);
    send_word(OP_SPARE_HI, 3, 3, KIND_PLAYER, 0, 0);
    send_word(OP_CLEAR, 0, 0, KIND_PLAYER, 0, 0);
    send_word(OP_READ, 75, 478, KIND_PLAYER, 0, 0);
    random_words(100);

    settle();
    write_sizes(1, 1, 1, 1, 1, 1);
    random_words(100);

    settle();
    write_sizes(4, 32, 4, 32, 4, 32);
    random_words(100);

    // out-of-range sizes get clamped; spare indexes are ignored
    settle();
    write_sizes(0, 0, 7, 63, 61, 40);
    put_reg(CFG_SPARE_LO, $urandom_range(0, 63));
    put_reg(CFG_SPARE_HI, $urandom_range(0, 63));
    cfg_we <= 1'b0;
    @(negedge clk);
    random_words(100);

    settle();
    write_sizes($urandom_range(1, 4), $urandom_range(1, 32), $urandom_range(1, 4),
                $urandom_range(1, 32), $urandom_range(1, 4), $urandom_range(1, 32));
    random_words(100);

    in_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sbf_pkg.sv
rtl/sbf_if.sv
rtl/sbf_ctrl.sv
rtl/sbf_dp.sv
rtl/sprite_blit_frame_buffer.sv
tb/sv/sbf_blit_checker.sv
tb/sv/tb_sprite_blit_frame_buffer.sv
